FILE: sv/tlc_pkg.sv
// shared constants, types and helpers for the two-level cache
package tlc_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 20;
  localparam int WB_W      = 2;
  localparam int OFF_W     = 6;
  localparam int WSEL_W    = OFF_W - WB_W;
  localparam int BLK_WORDS = 2 ** WSEL_W;
  localparam int LINE_W    = WORD_W * BLK_WORDS;
  localparam int BLK_W     = 14;
  localparam int TAG_W     = 6;
  localparam int IDX_W     = BLK_W - TAG_W;
  localparam int L1_LINES  = 2 ** IDX_W;
  localparam int L2_SETS   = 2 ** IDX_W;
  localparam int L2_ROW_W  = IDX_W + 1;
  localparam int BACK_ROWS = 2 ** BLK_W;
  localparam int COST_W    = 16;
  localparam int NCOST     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 20;
  localparam int TOTAL_W   = 32;
  localparam int ACT_W     = 2;

  localparam logic [ADDR_W:0] BACKING_LIMIT = (ADDR_W + 1)'(1048576);
  localparam logic [ADDR_W:0] WORD_STEP     = (ADDR_W + 1)'(4);

  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_INVAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CI_L1_RD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CI_L1_WR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CI_L2_RD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CI_L2_WR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CI_BK_RD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CI_BK_WR = 3'd5;

  typedef logic [LINE_W-1:0] line_t;

  typedef struct packed {
    logic start;
    logic add;
    logic clear;
  } acc_ctl_t;

  function automatic line_t put_word(line_t line, logic [WSEL_W-1:0] sel,
                                     logic [WORD_W-1:0] data);
    line_t res;
    res = line;
    for (int i = 0; i < BLK_WORDS; i++) begin
      if (sel == WSEL_W'(i)) res[i*WORD_W +: WORD_W] = data;
    end
    return res;
  endfunction

endpackage

FILE: sv/tlc_acc.sv
// running time total and per-request time, the per-request time saturating
module tlc_acc
  import tlc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  acc_ctl_t           ctl,
  input  logic [COST_W-1:0]  add_val,
  output logic [TOTAL_W-1:0] total_next,
  output logic [ACC_W-1:0]   item_next
);

  logic [TOTAL_W-1:0] total;
  logic [ACC_W-1:0]   item;
  logic [ACC_W:0]     item_sum;
  logic [COST_W-1:0]  inc;

  always_comb begin
    inc = ctl.add ? add_val : '0;
    item_sum = {1'b0, item} + (ACC_W + 1)'(inc);
    if (ctl.start) begin
      item_next = '0;
    end else if (item_sum[ACC_W]) begin
      item_next = '1;
    end else begin
      item_next = item_sum[ACC_W-1:0];
    end
    total_next = ctl.clear ? '0 : total + TOTAL_W'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      item  <= '0;
    end else begin
      total <= total_next;
      item  <= item_next;
    end
  end

endmodule

FILE: sv/two_level_cache_with_backing_store.sv
// two-level write-back cache over a block-wide backing store
//
// Requests arrive on in_valid/in_ready with action, address and write_data;
// each gives exactly one result on out_valid/out_ready. Lines move as whole
// 512-bit blocks, one memory row per cycle.
// An L1 hit, clear-time and invalidate register their result from the state
// after acceptance, and the next request is taken only back in idle, so a
// new request waits until the last has put its result in the output register.
// An L1 miss walks L2 (tag read, check, data read) and, on an L2 miss, a
// backing block read plus an optional dirty victim write; a dirty L1 victim
// repeats the L2 walk. The sequencer holds one request at a time, set by the
// single read port of each memory.
// The result sits in an output register; when the receiver stalls, the
// sequencer finishes the next request up to its last step and waits there.
// After reset the backing store, all 16384 blocks, is zeroed one block per
// cycle; in_ready stays low meanwhile, cost registers can still be written.
// The user must write cost registers through cfg_we/cfg_index/cfg_data only
// while the block is idle (not enforced by it); unknown indexes are ignored.
module two_level_cache_with_backing_store
  import tlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     action,
  input  logic [ADDR_W-1:0]    address,
  input  logic [WORD_W-1:0]    write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    read_data,
  output logic [TOTAL_W-1:0]   total_time,
  output logic [ACC_W-1:0]     access_time,
  output logic                 first_level_hit,
  output logic                 status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MISC   = 4'd2;
  localparam logic [3:0] ST_LOOKUP = 4'd3;
  localparam logic [3:0] ST_L2TAG  = 4'd4;
  localparam logic [3:0] ST_L2CHK  = 4'd5;
  localparam logic [3:0] ST_L2RD   = 4'd6;
  localparam logic [3:0] ST_BRD    = 4'd7;
  localparam logic [3:0] ST_VRD    = 4'd8;
  localparam logic [3:0] ST_L2FILL = 4'd9;
  localparam logic [3:0] ST_L1FILL = 4'd10;

  logic [3:0] state;
  logic [BLK_W-1:0] clr_cnt;

  logic [COST_W-1:0] cost [NCOST];

  // memories
  line_t            l1_data [L1_LINES];
  logic [TAG_W-1:0] l1_tag [L1_LINES];
  logic [2*TAG_W-1:0] l2_tag [L2_SETS];
  line_t            l2_data [2*L2_SETS];
  line_t            back [BACK_ROWS];

  line_t              l1_data_rd, l2_data_rd, back_rd;
  logic [TAG_W-1:0]   l1_tag_rd;
  logic [2*TAG_W-1:0] l2_tag_rd;

  // per-line state bits
  logic [L1_LINES-1:0] l1_valid, l1_dirty;
  logic [1:0]          l2_valid [L2_SETS];
  logic [1:0]          l2_dirty [L2_SETS];
  logic [L2_SETS-1:0]  lru;

  // request registers
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] wdata_r;
  logic              oor_r;
  logic              ph;
  logic [TAG_W-1:0]  v_tag;
  logic              v_dirty;
  logic              way_r;
  logic              vd2_r;
  logic [TAG_W-1:0]  vt2_r;
  line_t             lbuf, vbuf, tmp;

  // control
  logic              out_free, emit, hit1, w0hit, w1hit, l2hit, hit_way, fill_way;
  logic              l2_done, wr_act, in_oor;
  logic [BLK_W-1:0]  blk;
  logic [IDX_W-1:0]  idx, in_idx;
  logic [TAG_W-1:0]  tag, req_tag;
  logic [WSEL_W-1:0] wsel;
  logic [ADDR_W:0]   in_end;
  acc_ctl_t          acc_ctl;
  logic [CFG_IDX_W-1:0] cost_sel;
  logic [COST_W-1:0] add_val;
  logic [TOTAL_W-1:0] total_next;
  logic [ACC_W-1:0]  item_next;
  logic [WORD_W-1:0] rdata;

  logic                l1_re, l1_we, l2t_re, l2t_we, l2d_re, l2d_we, bk_re, bk_we;
  line_t               l1_wdata, l2d_wdata, bk_wdata;
  logic [2*TAG_W-1:0]  l2t_wdata;
  logic [IDX_W-1:0]    l1_raddr;
  logic [L2_ROW_W-1:0] l2d_raddr, l2d_waddr;
  logic [BLK_W-1:0]    bk_raddr, bk_waddr;

  assign blk     = addr_r[ADDR_W-1:OFF_W];
  assign idx     = blk[IDX_W-1:0];
  assign tag     = blk[BLK_W-1:IDX_W];
  assign wsel    = addr_r[OFF_W-1:WB_W];
  assign wr_act  = (act_r == ACT_WRITE);
  assign req_tag = ph ? v_tag : tag;
  assign in_idx  = address[OFF_W+IDX_W-1:OFF_W];
  assign in_end  = {1'b0, address[ADDR_W-1:WB_W], {WB_W{1'b0}}} + WORD_STEP;
  assign in_oor  = (in_end > BACKING_LIMIT);
  assign out_free = !out_valid || out_ready;
  assign add_val = cost[cost_sel];

  always_comb begin
    hit1     = l1_valid[idx] && (l1_tag_rd == tag);
    w0hit    = l2_valid[idx][0] && (l2_tag_rd[TAG_W-1:0] == req_tag);
    w1hit    = l2_valid[idx][1] && (l2_tag_rd[2*TAG_W-1:TAG_W] == req_tag);
    l2hit    = w0hit || w1hit;
    hit_way  = !w0hit;
    if (!l2_valid[idx][0]) begin
      fill_way = 1'b0;
    end else if (!l2_valid[idx][1]) begin
      fill_way = 1'b1;
    end else begin
      fill_way = lru[idx];
    end

    in_ready  = 1'b0;
    emit      = 1'b0;
    l2_done   = 1'b0;
    acc_ctl   = '0;
    cost_sel  = CI_L1_RD;
    rdata     = '0;
    l1_re     = 1'b0;
    l1_we     = 1'b0;
    l1_raddr  = in_idx;
    l1_wdata  = lbuf;
    l2t_re    = 1'b0;
    l2t_we    = 1'b0;
    l2t_wdata = l2_tag_rd;
    l2d_re    = 1'b0;
    l2d_we    = 1'b0;
    l2d_raddr = {idx, way_r};
    l2d_waddr = {idx, way_r};
    l2d_wdata = vbuf;
    bk_re     = 1'b0;
    bk_we     = 1'b0;
    bk_raddr  = {req_tag, idx};
    bk_waddr  = {vt2_r, idx};
    bk_wdata  = l2_data_rd;

    unique case (state)
      ST_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        bk_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          l1_re = 1'b1;
          acc_ctl.start = 1'b1;
        end
      end
      ST_MISC: begin
        if (out_free) begin
          emit = 1'b1;
          acc_ctl.clear = (act_r == ACT_CLEAR);
        end
      end
      ST_LOOKUP: begin
        if (hit1 && out_free) begin
          emit = 1'b1;
          acc_ctl.add = 1'b1;
          cost_sel = wr_act ? CI_L1_WR : CI_L1_RD;
          rdata = wr_act ? '0 : l1_data_rd[wsel*WORD_W +: WORD_W];
          l1_we = wr_act;
          l1_wdata = put_word(l1_data_rd, wsel, wdata_r);
        end
      end
      ST_L2TAG: begin
        l2t_re = 1'b1;
      end
      ST_L2CHK: begin
        if (l2hit) begin
          if (ph) begin
            l2d_we = 1'b1;
            l2d_waddr = {idx, hit_way};
            acc_ctl.add = 1'b1;
            cost_sel = CI_L2_WR;
            l2_done = 1'b1;
          end else begin
            l2d_re = 1'b1;
            l2d_raddr = {idx, hit_way};
          end
        end else begin
          bk_re = 1'b1;
        end
      end
      ST_L2RD: begin
        acc_ctl.add = 1'b1;
        cost_sel = CI_L2_RD;
        l2_done = 1'b1;
      end
      ST_BRD: begin
        acc_ctl.add = 1'b1;
        cost_sel = CI_BK_RD;
        l2d_re = vd2_r;
      end
      ST_VRD: begin
        bk_we = 1'b1;
        acc_ctl.add = 1'b1;
        cost_sel = CI_BK_WR;
      end
      ST_L2FILL: begin
        l2d_we = 1'b1;
        l2d_wdata = ph ? vbuf : tmp;
        l2t_we = 1'b1;
        l2t_wdata = way_r ? {req_tag, l2_tag_rd[TAG_W-1:0]}
                          : {l2_tag_rd[2*TAG_W-1:TAG_W], req_tag};
        acc_ctl.add = 1'b1;
        cost_sel = ph ? CI_L2_WR : CI_L2_RD;
        l2_done = 1'b1;
      end
      ST_L1FILL: begin
        if (out_free) begin
          emit = 1'b1;
          acc_ctl.add = 1'b1;
          cost_sel = wr_act ? CI_L1_WR : CI_L1_RD;
          rdata = wr_act ? '0 : lbuf[wsel*WORD_W +: WORD_W];
          l1_we = 1'b1;
          l1_wdata = wr_act ? put_word(lbuf, wsel, wdata_r) : lbuf;
        end
      end
      default: begin
      end
    endcase
  end

  tlc_acc u_acc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (acc_ctl),
    .add_val    (add_val),
    .total_next (total_next),
    .item_next  (item_next)
  );

  // memory ports
  always_ff @(posedge clk) begin
    if (l1_re) begin
      l1_data_rd <= l1_data[l1_raddr];
      l1_tag_rd  <= l1_tag[l1_raddr];
    end
    if (l1_we) begin
      l1_data[idx] <= l1_wdata;
      l1_tag[idx]  <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (l2t_re) l2_tag_rd <= l2_tag[idx];
    if (l2t_we) l2_tag[idx] <= l2t_wdata;
  end

  always_ff @(posedge clk) begin
    if (l2d_re) l2_data_rd <= l2_data[l2d_raddr];
    if (l2d_we) l2_data[l2d_waddr] <= l2d_wdata;
  end

  always_ff @(posedge clk) begin
    if (bk_re) back_rd <= back[bk_raddr];
    if (bk_we) back[bk_waddr] <= bk_wdata;
  end

  // cost registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cost[CI_L1_RD] <= COST_W'(1);
      cost[CI_L1_WR] <= COST_W'(1);
      cost[CI_L2_RD] <= COST_W'(10);
      cost[CI_L2_WR] <= COST_W'(10);
      cost[CI_BK_RD] <= COST_W'(100);
      cost[CI_BK_WR] <= COST_W'(50);
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NCOST))) begin
      cost[cfg_index] <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      read_data       <= rdata;
      total_time      <= total_next;
      access_time     <= item_next;
      first_level_hit <= (state == ST_LOOKUP);
      status          <= (state == ST_MISC) && oor_r;
    end
  end

  // request payload and buffers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_r   <= action;
      addr_r  <= {address[ADDR_W-1:WB_W], {WB_W{1'b0}}};
      wdata_r <= write_data;
      oor_r   <= in_oor;
    end
    if (state == ST_LOOKUP && !hit1) begin
      v_tag   <= l1_tag_rd;
      v_dirty <= l1_valid[idx] && l1_dirty[idx];
      vbuf    <= l1_data_rd;
    end
    if (state == ST_L2CHK) begin
      way_r <= l2hit ? hit_way : fill_way;
      vd2_r <= l2_valid[idx][fill_way] && l2_dirty[idx][fill_way];
      vt2_r <= fill_way ? l2_tag_rd[2*TAG_W-1:TAG_W] : l2_tag_rd[TAG_W-1:0];
    end
    if (state == ST_BRD) tmp <= back_rd;
    if (state == ST_L2RD) lbuf <= l2_data_rd;
    if (state == ST_L2FILL && !ph) lbuf <= tmp;
  end

  // sequencer and state bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      ph       <= 1'b0;
      l1_valid <= '0;
      l1_dirty <= '0;
      lru      <= '0;
      for (int i = 0; i < L2_SETS; i++) begin
        l2_valid[i] <= '0;
        l2_dirty[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + BLK_W'(1);
          if (clr_cnt == {BLK_W{1'b1}}) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            ph <= 1'b0;
            if ((action == ACT_READ || action == ACT_WRITE) && !in_oor) begin
              state <= ST_LOOKUP;
            end else begin
              state <= ST_MISC;
            end
          end
        end
        ST_MISC: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (act_r == ACT_INVAL) begin
              l1_valid <= '0;
              l1_dirty <= '0;
              lru      <= '0;
              for (int i = 0; i < L2_SETS; i++) begin
                l2_valid[i] <= '0;
                l2_dirty[i] <= '0;
              end
            end
          end
        end
        ST_LOOKUP: begin
          if (!hit1) begin
            state <= ST_L2TAG;
          end else if (out_free) begin
            state <= ST_IDLE;
            if (wr_act) l1_dirty[idx] <= 1'b1;
          end
        end
        ST_L2TAG: begin
          state <= ST_L2CHK;
        end
        ST_L2CHK: begin
          if (l2hit) begin
            lru[idx] <= !hit_way;
            if (ph) begin
              l2_dirty[idx][hit_way] <= 1'b1;
            end else begin
              state <= ST_L2RD;
            end
          end else begin
            state <= ST_BRD;
          end
        end
        ST_L2RD: begin
        end
        ST_BRD: begin
          state <= vd2_r ? ST_VRD : ST_L2FILL;
        end
        ST_VRD: begin
          state <= ST_L2FILL;
        end
        ST_L2FILL: begin
          l2_valid[idx][way_r] <= 1'b1;
          l2_dirty[idx][way_r] <= ph;
          lru[idx] <= !way_r;
        end
        ST_L1FILL: begin
          if (out_free) begin
            state <= ST_IDLE;
            l1_valid[idx] <= 1'b1;
            l1_dirty[idx] <= wr_act;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // end of an L2 walk: fetch done, then maybe write back the L1 victim
      if (l2_done) begin
        if (!ph && v_dirty) begin
          ph    <= 1'b1;
          state <= ST_L2TAG;
        end else begin
          state <= ST_L1FILL;
        end
      end
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request taken during backing store clear");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_LOOKUP || state == ST_MISC))
    else $error("accepted request did not start");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_L1FILL && emit) |=> l1_valid[$past(idx)])
    else $error("l1 fill left line invalid");

  a_misc_no_time: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MISC && emit) |=> (access_time == '0 && !first_level_hit))
    else $error("non-access request charged time");

  a_writeback_only_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VRD) |-> vd2_r)
    else $error("clean l2 victim written back");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the two-level write-back cache
`timescale 1ns / 1ps

module testbench;
  import tlc_pkg::*;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t blk_words_t [BLK_WORDS];

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [ADDR_W-1:0] addr;
    word_t             data;
  } cache_req_t;

  typedef struct {
    word_t              rdata;
    logic [TOTAL_W-1:0] total;
    logic [ACC_W-1:0]   acc;
    logic               hit;
    logic               stat;
  } cache_resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACT_W-1:0]     action = '0;
  logic [ADDR_W-1:0]    address = '0;
  word_t                write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  word_t                read_data;
  logic [TOTAL_W-1:0]   total_time;
  logic [ACC_W-1:0]     access_time;
  logic                 first_level_hit;
  logic                 status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COST_W-1:0]    cfg_data = '0;

  two_level_cache_with_backing_store uut (.*);

  always #5 clk = ~clk;

  // shadow copy of the cache hierarchy
  logic [COST_W-1:0]  cost [NCOST];
  word_t              l1_data [L1_LINES][BLK_WORDS];
  logic [TAG_W-1:0]   l1_tag [L1_LINES];
  logic               l1_vld [L1_LINES];
  logic               l1_drt [L1_LINES];
  word_t              l2_data [2*L2_SETS][BLK_WORDS];
  logic [TAG_W-1:0]   l2_tag [2*L2_SETS];
  logic               l2_vld [2*L2_SETS];
  logic               l2_drt [2*L2_SETS];
  logic               l2_lru [L2_SETS];
  word_t              mem_words [BACK_ROWS*BLK_WORDS];
  logic [TOTAL_W-1:0] run_total;
  int unsigned        item_cost;

  cache_req_t  pending_reqs [$];
  cache_resp_t expected_resps [$];
  int          errors = 0;

  function automatic void bill(logic [COST_W-1:0] c);
    run_total += c;
    item_cost += c;
  endfunction

  function automatic blk_words_t mem_read(int unsigned blk);
    blk_words_t b;
    for (int i = 0; i < BLK_WORDS; i++) b[i] = mem_words[blk*BLK_WORDS + i];
    bill(cost[CI_BK_RD]);
    return b;
  endfunction

  function automatic void mem_write(int unsigned blk, blk_words_t b);
    for (int i = 0; i < BLK_WORDS; i++) mem_words[blk*BLK_WORDS + i] = b[i];
    bill(cost[CI_BK_WR]);
  endfunction

  // returns the L2 row holding blk, filling it on a miss
  function automatic int unsigned l2_find(int unsigned blk);
    int unsigned set, row, way;
    logic [TAG_W-1:0] tg;
    blk_words_t fill, victim;
    set = blk % L2_SETS;
    tg  = TAG_W'(blk / L2_SETS);
    if (l2_vld[2*set] && l2_tag[2*set] == tg) way = 0;
    else if (l2_vld[2*set+1] && l2_tag[2*set+1] == tg) way = 1;
    else begin
      if (!l2_vld[2*set]) way = 0;
      else if (!l2_vld[2*set+1]) way = 1;
      else way = l2_lru[set];
      row = 2*set + way;
      fill = mem_read(blk);
      if (l2_vld[row] && l2_drt[row]) begin
        victim = l2_data[row];
        mem_write(l2_tag[row]*L2_SETS + set, victim);
      end
      l2_data[row] = fill;
      l2_vld[row] = 1'b1;
      l2_tag[row] = tg;
      l2_drt[row] = 1'b0;
    end
    l2_lru[set] = ~way[0];
    return 2*set + way;
  endfunction

  function automatic cache_resp_t predict_access(cache_req_t r);
    cache_resp_t res;
    int unsigned blk, idx, row, wsel;
    blk_words_t fetched;
    res = '{default: '0};
    item_cost = 0;
    case (r.act)
      ACT_CLEAR: run_total = '0;
      ACT_INVAL: begin
        for (int i = 0; i < L1_LINES; i++) begin
          l1_vld[i] = 1'b0;
          l1_drt[i] = 1'b0;
        end
        for (int i = 0; i < 2*L2_SETS; i++) begin
          l2_vld[i] = 1'b0;
          l2_drt[i] = 1'b0;
        end
        for (int i = 0; i < L2_SETS; i++) l2_lru[i] = 1'b0;
      end
      default: begin
        // the whole 20-bit space fits in the backing store, so no range error
        blk  = r.addr[ADDR_W-1:OFF_W];
        idx  = blk % L1_LINES;
        wsel = r.addr[OFF_W-1:WB_W];
        if (l1_vld[idx] && l1_tag[idx] == TAG_W'(blk / L1_LINES)) res.hit = 1'b1;
        else begin
          row = l2_find(blk);
          fetched = l2_data[row];
          bill(cost[CI_L2_RD]);
          if (l1_vld[idx] && l1_drt[idx]) begin
            row = l2_find(l1_tag[idx]*L1_LINES + idx);
            l2_data[row] = l1_data[idx];
            l2_drt[row] = 1'b1;
            bill(cost[CI_L2_WR]);
          end
          l1_data[idx] = fetched;
          l1_vld[idx] = 1'b1;
          l1_tag[idx] = TAG_W'(blk / L1_LINES);
          l1_drt[idx] = 1'b0;
        end
        if (r.act == ACT_READ) begin
          res.rdata = l1_data[idx][wsel];
          bill(cost[CI_L1_RD]);
        end else begin
          l1_data[idx][wsel] = r.data;
          l1_drt[idx] = 1'b1;
          bill(cost[CI_L1_WR]);
        end
      end
    endcase
    res.total = run_total;
    res.acc = (item_cost > 20'hFFFFF) ? 20'hFFFFF : ACC_W'(item_cost);
    return res;
  endfunction

  // driver: bursts of requests separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    cache_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_resps.push_back(predict_access('{action, address, write_data}));
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          action <= nxt.act;
          address <= nxt.addr;
          write_data <= nxt.data;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver stalls on a rotating pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_pos = 0;
  always @(posedge clk) begin
    cache_resp_t exp_r;
    if (out_valid && out_ready && !rst) begin
      if (expected_resps.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (read_data !== exp_r.rdata) begin
          $error("read_data exp %h got %h", exp_r.rdata, read_data); errors++;
        end
        if (total_time !== exp_r.total) begin
          $error("total_time exp %0d got %0d", exp_r.total, total_time); errors++;
        end
        if (access_time !== exp_r.acc) begin
          $error("access_time exp %0d got %0d", exp_r.acc, access_time); errors++;
        end
        if (first_level_hit !== exp_r.hit) begin
          $error("first_level_hit exp %b got %b", exp_r.hit, first_level_hit); errors++;
        end
        if (status !== exp_r.stat) begin
          $error("status exp %b got %b", exp_r.stat, status); errors++;
        end
      end
    end
    pat_pos = (pat_pos + 1) % 16;
    if (pat_pos == 0 && $urandom_range(0, 7) == 0)
      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
    out_ready <= stall_pat[pat_pos];
  end

  function automatic logic [ADDR_W-1:0] pack_addr(int unsigned tg, int unsigned idx,
                                                   int unsigned wsel, int unsigned bsel);
    return {TAG_W'(tg), IDX_W'(idx), WSEL_W'(wsel), WB_W'(bsel)};
  endfunction

  function automatic cache_req_t random_req();
    cache_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 46) r.act = ACT_READ;
    else if (pick < 94) r.act = ACT_WRITE;
    else if (pick < 98) r.act = ACT_CLEAR;
    else r.act = ACT_INVAL;
    // mostly a few hot sets with several tags, to force evictions in both levels
    if ($urandom_range(0, 4) == 0) r.addr = ADDR_W'($urandom);
    else r.addr = pack_addr($urandom_range(0, 4), $urandom_range(0, 3),
                            $urandom_range(0, 15), $urandom_range(0, 3));
    r.data = $urandom;
    return r;
  endfunction

  task automatic write_cost(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NCOST) cost[idx] = val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic add(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] ad, word_t d);
    pending_reqs.push_back('{a, ad, d});
  endtask

  initial begin
    cost = '{16'd1, 16'd1, 16'd10, 16'd10, 16'd100, 16'd50};
    for (int i = 0; i < L1_LINES; i++) begin
      l1_vld[i] = 1'b0; l1_drt[i] = 1'b0; l1_tag[i] = '0;
    end
    for (int i = 0; i < 2*L2_SETS; i++) begin
      l2_vld[i] = 1'b0; l2_drt[i] = 1'b0; l2_tag[i] = '0;
    end
    for (int i = 0; i < L2_SETS; i++) l2_lru[i] = 1'b0;
    for (int i = 0; i < BACK_ROWS*BLK_WORDS; i++) mem_words[i] = '0;
    run_total = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, misses, hits, dirty victims through both levels
    add(ACT_READ, '0, '0);
    add(ACT_WRITE, '0, 32'hFFFF_FFFF);
    add(ACT_READ, 20'h00003, '0);
    add(ACT_WRITE, 20'hFFFFF, 32'hA5A5_5A5A);
    add(ACT_READ, 20'hFFFFC, '0);
    for (int t = 1; t < 4; t++) begin
      add(ACT_WRITE, pack_addr(t, 0, t, 0), 32'h1000_0000 * t);
      add(ACT_READ, pack_addr(t, 0, t, 1), '0);
    end
    add(ACT_READ, pack_addr(0, 0, 0, 0), '0);
    add(ACT_READ, pack_addr(1, 0, 1, 2), '0);
    add(ACT_READ, pack_addr(63, 255, 15, 3), '0);
    add(ACT_CLEAR, 20'hFFFFF, 32'hFFFF_FFFF);
    add(ACT_READ, '0, '0);
    add(ACT_WRITE, pack_addr(5, 7, 2, 0), 32'h1234_5678);
    add(ACT_INVAL, '0, '0);
    add(ACT_READ, pack_addr(5, 7, 2, 0), '0);
    add(ACT_READ, 20'hFFFFC, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < NCOST; i++) begin
        case (ph)
          0: write_cost(CFG_IDX_W'(i), '0);
          1: write_cost(CFG_IDX_W'(i), 16'hFFFF);
          2: write_cost(CFG_IDX_W'(i), 16'($urandom));
          default: write_cost(CFG_IDX_W'(i), 16'($urandom_range(0, 200)));
        endcase
      end
      write_cost(CFG_IDX_W'(NCOST + ph % 2), 16'($urandom));
      for (int i = 0; i < 207; i++) pending_reqs.push_back(random_req());
      drain();
    end

    if (errors == 0 && expected_resps.size() == 0) begin
      $display("two_level_cache_with_backing_store regression: pass");
    end else begin
      $display("two_level_cache_with_backing_store regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("two_level_cache_with_backing_store regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/tlc_pkg.sv
sv/tlc_acc.sv
sv/two_level_cache_with_backing_store.sv
dv/testbench.sv
